### hw/rtl/websocket_frame_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_macros
// Assertion macros for the deframer; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define WSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WSD_ASSERT_NEVER(lbl, cond, msg) \
	`WSD_ASSERT(lbl, !(cond), msg)
`else
`define WSD_ASSERT(lbl, prop, msg)
`define WSD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int MAX_CHUNK_BYTES = 8191;
	localparam int CNT_W = $clog2(MAX_CHUNK_BYTES + 1);
	localparam int LEN_W = 16;
	localparam logic [12:0] LEN_FIELD_MAX = 13'h1FFF;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_NOT_TEXT = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       chunk_end;
	} ws_in_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        chunk_done;
		logic [1:0]  status;
		logic [12:0] payload_length;
	} ws_out_t;

	// classified request from the parser to the output side
	typedef struct packed {
		logic [7:0]       data;
		logic [7:0]       key;
		logic             is_payload;
		logic             is_end;
		logic [1:0]       status;
		logic             len_big;
		logic [LEN_W-1:0] len_low;
	} wsd_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wsd_q_stat_t;

endpackage

### hw/rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Text-frame deframer: parser, request queue, output stage.
//
//   channel   handshake     payload
//   item      push / full   ws_in_t  (in_byte, chunk_end)
//   result    pop / empty   ws_out_t (payload_byte, byte_valid, chunk_done,
//                                     status, payload_length)
//
// A byte is taken each cycle unless full; parser state updates with it.
// Results pass through the request queue and the output register.
// full rises only when the four-entry request queue is full.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_top_macros.svh"
module websocket_frame_deframer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  wsd_pkg::ws_in_t  item,
	output logic             empty,
	input  logic             pop,
	output wsd_pkg::ws_out_t result
);
	import wsd_pkg::*;

	wsd_op_t     op, head;
	logic        op_push, accept, q_pop;
	wsd_q_stat_t q_stat;

	assign full = q_stat.full;
	assign accept = push && !q_stat.full;

	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.accept  (accept),
		.op      (op),
		.op_push (op_push)
	);

	wsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.din    (op),
		.pop    (q_pop),
		.dout   (head),
		.stat   (q_stat)
	);

	wsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.pop    (pop),
		.result (result),
		.empty  (empty)
	);

	`WSD_ASSERT(a_full_has_data, q_stat.full |-> !q_stat.empty, "queue full yet empty")
	`WSD_ASSERT_NEVER(a_empty_result, !empty && !result.chunk_done && !result.byte_valid, "result with no content")
	`WSD_ASSERT_NEVER(a_status_no_end, !empty && !result.chunk_done && result.status != ST_OK, "status off chunk end")
	`WSD_ASSERT_NEVER(a_len_not_ok, !empty && result.payload_length != 13'd0 && result.status != ST_OK, "length with error")

endmodule

### hw/rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: tracks frame phase, length, mask key; classifies each byte.
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  wsd_pkg::ws_in_t item,
	input  logic            accept,
	output wsd_pkg::wsd_op_t op,
	output logic            op_push
);
	import wsd_pkg::*;

	localparam logic [2:0] PH_FIRST = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_TAIL = 3'd5;

	logic [2:0]       phase_q, phase_n;
	logic [3:0]       hcnt_q, hcnt_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             big_q, big_n;
	logic             ext16_q, ext16_n;
	logic             mask_q, mask_n;
	logic [31:0]      key_q, key_n;
	logic [CNT_W-1:0] pcnt_q, pcnt_n;
	logic             err_q, err_n;
	logic [CNT_W-1:0] chunk_q, chunk_n;

	logic       after_len, start_pay, is_pay;
	logic [7:0] key_b, b;
	logic [1:0] st;

	assign b = item.in_byte;

	always_comb begin
		phase_n = phase_q;
		hcnt_n = hcnt_q;
		len_n = len_q;
		big_n = big_q;
		ext16_n = ext16_q;
		mask_n = mask_q;
		key_n = key_q;
		pcnt_n = pcnt_q;
		err_n = err_q;
		chunk_n = chunk_q;
		after_len = 1'b0;
		start_pay = 1'b0;
		is_pay = 1'b0;
		key_b = 8'h00;
		if (chunk_q < CNT_W'(MAX_CHUNK_BYTES)) begin
			chunk_n = chunk_q + 1'b1;
			unique case (phase_q)
				PH_FIRST: begin
					if (b[3:0] != 4'h1) err_n = 1'b1;
					phase_n = PH_SECOND;
				end
				PH_SECOND: begin
					if (err_q) begin
						phase_n = PH_TAIL;
					end else begin
						mask_n = b[7];
						ext16_n = (b[6:0] == 7'd126);
						hcnt_n = 4'd0;
						big_n = 1'b0;
						if (b[6:1] == 6'h3F) begin
							len_n = '0;
							phase_n = PH_EXTLEN;
						end else begin
							len_n = LEN_W'(b[6:0]);
							after_len = 1'b1;
						end
					end
				end
				PH_EXTLEN: begin
					len_n = {len_q[LEN_W-9:0], b};
					big_n = big_q | (len_q[LEN_W-1:LEN_W-8] != 8'h00);
					hcnt_n = hcnt_q + 1'b1;
					if (hcnt_n >= (ext16_q ? 4'd2 : 4'd8)) after_len = 1'b1;
				end
				PH_MASK: begin
					key_n = {key_q[23:0], b};
					hcnt_n = hcnt_q + 1'b1;
					if (hcnt_n >= 4'd4) start_pay = 1'b1;
				end
				PH_PAYLOAD: begin
					is_pay = 1'b1;
					if (mask_q) begin
						unique case (pcnt_q[1:0])
							2'd0: key_b = key_q[31:24];
							2'd1: key_b = key_q[23:16];
							2'd2: key_b = key_q[15:8];
							default: key_b = key_q[7:0];
						endcase
					end
					pcnt_n = pcnt_q + 1'b1;
					if (!big_q && (LEN_W'(pcnt_n) >= len_q)) phase_n = PH_TAIL;
				end
				default: ;
			endcase
			if (after_len) begin
				hcnt_n = 4'd0;
				if (mask_n) phase_n = PH_MASK;
				else start_pay = 1'b1;
			end
			if (start_pay) begin
				pcnt_n = '0;
				phase_n = (!big_n && len_n == '0) ? PH_TAIL : PH_PAYLOAD;
			end
		end
	end

	always_comb begin
		priority if (phase_n == PH_FIRST || phase_n == PH_SECOND) st = ST_SHORT;
		else if (err_n) st = ST_NOT_TEXT;
		else if (phase_n != PH_TAIL) st = ST_SHORT;
		else st = ST_OK;
	end

	always_comb begin
		op.data = b;
		op.key = key_b;
		op.is_payload = is_pay;
		op.is_end = item.chunk_end;
		op.status = st;
		op.len_big = big_n;
		op.len_low = len_n;
	end

	assign op_push = accept && (is_pay || item.chunk_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			hcnt_q <= '0;
			len_q <= '0;
			big_q <= 1'b0;
			ext16_q <= 1'b0;
			mask_q <= 1'b0;
			key_q <= '0;
			pcnt_q <= '0;
			err_q <= 1'b0;
			chunk_q <= '0;
		end else if (accept) begin
			if (item.chunk_end) begin
				phase_q <= PH_FIRST;
				hcnt_q <= '0;
				len_q <= '0;
				big_q <= 1'b0;
				ext16_q <= 1'b0;
				mask_q <= 1'b0;
				key_q <= '0;
				pcnt_q <= '0;
				err_q <= 1'b0;
				chunk_q <= '0;
			end else begin
				phase_q <= phase_n;
				hcnt_q <= hcnt_n;
				len_q <= len_n;
				big_q <= big_n;
				ext16_q <= ext16_n;
				mask_q <= mask_n;
				key_q <= key_n;
				pcnt_q <= pcnt_n;
				err_q <= err_n;
				chunk_q <= chunk_n;
			end
		end
	end

endmodule

### hw/rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Short request queue between parser and output stage.
// ----------------------------------------------------------------------------
module wsd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsd_pkg::wsd_op_t     din,
	input  logic                 pop,
	output wsd_pkg::wsd_op_t     dout,
	output wsd_pkg::wsd_q_stat_t stat
);
	import wsd_pkg::*;

	wsd_op_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign stat.full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks payload, saturates length, holds the result.
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wsd_pkg::wsd_op_t     head,
	input  wsd_pkg::wsd_q_stat_t q_stat,
	output logic                 q_pop,
	input  logic                 pop,
	output wsd_pkg::ws_out_t     result,
	output logic                 empty
);
	import wsd_pkg::*;

	ws_out_t     res_q, res_n;
	logic        vld_q;
	logic [12:0] sat;

	assign q_pop = !q_stat.empty && (!vld_q || pop);

	always_comb begin
		sat = (head.len_big || head.len_low > LEN_W'(LEN_FIELD_MAX)) ?
			LEN_FIELD_MAX : head.len_low[12:0];
		res_n.payload_byte = head.is_payload ? (head.data ^ head.key) : 8'h00;
		res_n.byte_valid = head.is_payload;
		res_n.chunk_done = head.is_end;
		res_n.status = head.is_end ? head.status : ST_OK;
		res_n.payload_length = (head.is_end && head.status == ST_OK) ? sat : 13'd0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (q_pop) vld_q <= 1'b1;
		else if (pop) vld_q <= 1'b0;
	end

	assign result = res_q;
	assign empty = !vld_q;

endmodule
